@@ rtl/slid_pkg.sv @@
// Shared types, operation and status codes for the sorted list block.
package slid_pkg;

  localparam int VALUE_W = 32;
  localparam int FIELD_W = 5;
  localparam logic [FIELD_W-1:0] FIELD_MAX = 5'd31;

  typedef logic signed [VALUE_W-1:0] value_t;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_COUNT  = 2'd2;

  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic   ins_en;
    logic   del_en;
    value_t value;
  } cell_ctl_t;

  function automatic logic [FIELD_W-1:0] sat_field(input logic [31:0] v);
    logic [FIELD_W-1:0] r;
    if (v > 32'(FIELD_MAX)) r = FIELD_MAX;
    else r = v[FIELD_W-1:0];
    return r;
  endfunction

endpackage

@@ rtl/slid_cell.sv @@
// One storage cell of the sorted chain: compare against the operand, shift left or right.
module slid_cell (
  input  logic                 clk,
  input  slid_pkg::cell_ctl_t  ctl,
  input  logic                 occ,
  input  logic                 left_lt,
  input  slid_pkg::value_t     left_entry,
  input  slid_pkg::value_t     right_entry,
  output slid_pkg::value_t     entry,
  output logic                 lt,
  output logic                 eq
);

  slid_pkg::value_t entry_r;
  slid_pkg::value_t entry_nxt;

  assign entry = entry_r;
  assign lt    = occ && (entry_r < ctl.value);
  assign eq    = occ && (entry_r == ctl.value);

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins_en) begin
      // Cells below the operand hold; the insertion slot takes the operand, the rest shift up.
      if (!lt) begin
        entry_nxt = left_lt ? ctl.value : left_entry;
      end
    end else if (ctl.del_en) begin
      if (!lt) begin
        entry_nxt = right_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

@@ rtl/sorted_list_insert_delete_count.sv @@
// A result is registered; out_tvalid rises in the cycle after its input is accepted.
// One op per cycle while in_tready is high; all cells compare and shift in the same cycle,
// so the cell contents and the fill counter are both settled before the next operation.
// in_tready stays high while the output register is empty or being drained.
// Reset clears the fill count and the output valid; cell contents are not cleared.
module sorted_list_insert_delete_count #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [1:0] kind, [33:2] value, [39:34] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [1:0] status, [6:2] match_count, [11:7] fill_level
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [1:0]       in_kind;
  slid_pkg::value_t in_value;
  logic             in_fire;

  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] fill_nxt;

  slid_pkg::cell_ctl_t ctl;
  slid_pkg::value_t    entry_q [CAPACITY];
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] eq_vec;
  logic [CAPACITY-1:0] le_vec;
  logic [CAPACITY:0]   lt_ext;
  logic [CAPACITY:0]   le_ext;
  logic [CNT_W-1:0]    lt_pos;
  logic [CNT_W-1:0]    le_pos;
  logic [CNT_W-1:0]    match_cnt;
  logic                full;
  logic                found;

  logic [1:0]                  status_nxt;
  logic [slid_pkg::FIELD_W-1:0] match_nxt;

  logic                         out_tvalid_r;
  logic [1:0]                   status_r;
  logic [slid_pkg::FIELD_W-1:0] match_r;
  logic [slid_pkg::FIELD_W-1:0] level_r;

  assign in_kind   = in_tdata[1:0];
  assign in_value  = signed'(in_tdata[33:2]);
  assign in_tready = !out_tvalid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign full  = (fill_r == CNT_W'(CAPACITY));
  assign found = |eq_vec;

  assign ctl.ins_en = in_fire && (in_kind == slid_pkg::KIND_INSERT) && !full;
  assign ctl.del_en = in_fire && (in_kind == slid_pkg::KIND_DELETE) && found;
  assign ctl.value  = in_value;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      slid_pkg::value_t left_entry;
      slid_pkg::value_t right_entry;
      logic             left_lt;

      assign occ[gi] = (CNT_W'(gi) < fill_r);

      if (gi == 0) begin : g_first
        assign left_lt    = 1'b1;
        assign left_entry = in_value;
      end else begin : g_mid
        assign left_lt    = lt_vec[gi-1];
        assign left_entry = entry_q[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign right_entry = '0;
      end else begin : g_inner
        assign right_entry = entry_q[gi+1];
      end

      slid_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .occ         (occ[gi]),
        .left_lt     (left_lt),
        .left_entry  (left_entry),
        .right_entry (right_entry),
        .entry       (entry_q[gi]),
        .lt          (lt_vec[gi]),
        .eq          (eq_vec[gi])
      );
    end
  endgenerate

  // Both flag vectors are prefixes of ones; their lengths come from the single edge.
  assign le_vec = lt_vec | eq_vec;
  assign lt_ext = {1'b0, lt_vec};
  assign le_ext = {1'b0, le_vec};

  always_comb begin
    lt_pos = '0;
    le_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (lt_ext[i] && !lt_ext[i+1]) lt_pos = lt_pos | CNT_W'(i + 1);
      if (le_ext[i] && !le_ext[i+1]) le_pos = le_pos | CNT_W'(i + 1);
    end
  end

  assign match_cnt = le_pos - lt_pos;

  always_comb begin
    fill_nxt   = fill_r;
    status_nxt = slid_pkg::STATUS_DONE;
    match_nxt  = '0;
    case (in_kind)
      slid_pkg::KIND_INSERT: begin
        if (full) status_nxt = slid_pkg::STATUS_FULL;
        else fill_nxt = fill_r + CNT_W'(1);
      end
      slid_pkg::KIND_DELETE: begin
        if (found) fill_nxt = fill_r - CNT_W'(1);
        else status_nxt = slid_pkg::STATUS_NOT_FOUND;
      end
      slid_pkg::KIND_COUNT: begin
        match_nxt = slid_pkg::sat_field(32'(match_cnt));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (in_fire) fill_r <= fill_nxt;
      if (in_tready) out_tvalid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_nxt;
      match_r  <= match_nxt;
      level_r  <= slid_pkg::sat_field(32'(fill_nxt));
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0, level_r, match_r, status_r};

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_kind == slid_pkg::KIND_INSERT) && !full)
      |=> (fill_r == $past(fill_r) + CNT_W'(1)))
    else $error("accepted insert did not grow the store");

  a_miss_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_kind == slid_pkg::KIND_DELETE) && !found) |=> $stable(fill_r))
    else $error("delete miss changed fill count");

  a_full_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_kind == slid_pkg::KIND_INSERT) && full)
      |=> (out_tvalid && (out_tdata[1:0] == slid_pkg::STATUS_FULL)))
    else $error("insert into full store not refused");

  generate
    for (gi = 0; gi < CAPACITY - 1; gi++) begin : g_order_chk
      a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        occ[gi+1] |-> (entry_q[gi] <= entry_q[gi+1]))
        else $error("stored entries out of order");
    end
  endgenerate
`endif

endmodule

@@ tb/sv/tb_sorted_list_insert_delete_count.sv @@
// Self-checking testbench for the sorted list block: queued stimulus, model-based checking.
module tb_sorted_list_insert_delete_count;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY     = 16;
  localparam int RANDOM_OPS   = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  // The 2-bit kind field has one code that the block ignores.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]                   status;
    logic [slid_pkg::FIELD_W-1:0] hit_count;
    logic [slid_pkg::FIELD_W-1:0] fill;
  } reply_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // [1:0] kind, [33:2] value, [39:34] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [1:0] status, [6:2] match_count, [11:7] fill_level

  logic [39:0]      op_queue[$];
  reply_t           pending_replies[$];
  slid_pkg::value_t sorted_vals[$];

  int in_gap      = 0;
  int out_stall   = 0;
  int sent_ops    = 0;
  int error_count = 0;
  int cycle_count = 0;

  sorted_list_insert_delete_count #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [slid_pkg::FIELD_W-1:0] clamp_field(input int n);
    return (n > int'(slid_pkg::FIELD_MAX)) ? slid_pkg::FIELD_MAX : n[slid_pkg::FIELD_W-1:0];
  endfunction

  // Mostly short gaps, a few long ones; every third block of 64 runs back to back.
  function automatic int pick_gap(input int n);
    int r;
    r = $urandom_range(0, 99);
    if (((n / 64) % 3) == 1) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Apply one operation to the shadow list and return the reply it should produce.
  function automatic reply_t apply_list_op(input logic [39:0] word);
    logic [1:0]       op;
    slid_pkg::value_t v;
    reply_t           rep;
    int               pos;
    int               hits;
    op   = word[1:0];
    v    = word[33:2];
    rep  = '0;
    hits = 0;
    rep.status = slid_pkg::STATUS_DONE;
    case (op)
      slid_pkg::KIND_INSERT: begin
        if (sorted_vals.size() >= CAPACITY) begin
          rep.status = slid_pkg::STATUS_FULL;
        end else begin
          pos = 0;
          while (pos < sorted_vals.size() && sorted_vals[pos] < v) pos++;
          sorted_vals.insert(pos, v);
        end
      end
      slid_pkg::KIND_DELETE: begin
        pos = 0;
        while (pos < sorted_vals.size() && sorted_vals[pos] != v) pos++;
        if (pos == sorted_vals.size()) rep.status = slid_pkg::STATUS_NOT_FOUND;
        else sorted_vals.delete(pos);
      end
      slid_pkg::KIND_COUNT: begin
        foreach (sorted_vals[i]) if (sorted_vals[i] == v) hits++;
        rep.hit_count = clamp_field(hits);
      end
      default: ;
    endcase
    rep.fill = clamp_field(sorted_vals.size());
    return rep;
  endfunction

  task automatic push_op(input logic [1:0] k, input slid_pkg::value_t v);
    op_queue.push_back({6'b0, v, k});
  endtask

  // Driver: predict on each accepted transaction, then present the next queued item.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) pending_replies.push_back(apply_list_op(in_tdata));
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap    <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (op_queue.size() > 0) begin
          in_tdata  <= op_queue.pop_front();
          in_tvalid <= 1'b1;
          in_gap    <= pick_gap(sent_ops);
          sent_ops  <= sent_ops + 1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest prediction, then stall at random.
  always @(posedge clk) begin : monitor
    reply_t got;
    reply_t want;
    int     r;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status    = out_tdata[1:0];
        got.hit_count = out_tdata[6:2];
        got.fill      = out_tdata[11:7];
        if (pending_replies.size() == 0) begin
          $display("%0t: unexpected result status=%0d match_count=%0d fill_level=%0d",
                   $realtime, got.status, got.hit_count, got.fill);
          error_count++;
        end else begin
          want = pending_replies.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, want.status, got.status);
            error_count++;
          end
          if (got.hit_count !== want.hit_count) begin
            $display("%0t: match_count expected %0d actual %0d",
                     $realtime, want.hit_count, got.hit_count);
            error_count++;
          end
          if (got.fill !== want.fill) begin
            $display("%0t: fill_level expected %0d actual %0d", $realtime, want.fill, got.fill);
            error_count++;
          end
        end
      end
      r = $urandom_range(0, 99);
      if (out_stall > 0) begin
        out_stall  <= out_stall - 1;
        out_tready <= 1'b0;
      end else if (((cycle_count / 500) % 4) == 2 || r < 75) begin
        out_tready <= 1'b1;
      end else if (r < 95) begin
        out_tready <= 1'b0;
        out_stall  <= $urandom_range(0, 2);
      end else begin
        out_tready <= 1'b0;
        out_stall  <= $urandom_range(10, 30);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int               i;
    int               r;
    int               r2;
    int               phase;
    logic [1:0]       k;
    slid_pkg::value_t v;

    // Directed: empty store, unused kind, extremes, duplicates, fill up, refuse when full.
    push_op(slid_pkg::KIND_COUNT, 32'sd0);
    push_op(slid_pkg::KIND_DELETE, 32'sd5);
    push_op(KIND_UNUSED, slid_pkg::value_t'(32'h7FFF_FFFF));
    push_op(slid_pkg::KIND_INSERT, slid_pkg::value_t'(32'h7FFF_FFFF));
    push_op(slid_pkg::KIND_INSERT, slid_pkg::value_t'(32'h8000_0000));
    push_op(slid_pkg::KIND_INSERT, 32'sd0);
    push_op(slid_pkg::KIND_INSERT, -32'sd1);
    push_op(slid_pkg::KIND_INSERT, slid_pkg::value_t'(32'h8000_0000));
    push_op(slid_pkg::KIND_COUNT, slid_pkg::value_t'(32'h8000_0000));
    push_op(slid_pkg::KIND_DELETE, slid_pkg::value_t'(32'h8000_0000));
    push_op(slid_pkg::KIND_DELETE, slid_pkg::value_t'(32'h7FFF_FFFF));
    push_op(slid_pkg::KIND_DELETE, 32'sd123);
    for (i = 0; i < 12; i++) push_op(slid_pkg::KIND_INSERT, 32'sd7);
    push_op(slid_pkg::KIND_INSERT, 32'sd9);
    push_op(slid_pkg::KIND_INSERT, slid_pkg::value_t'(32'h8000_0000));
    push_op(slid_pkg::KIND_COUNT, 32'sd7);

    // Random: alternate insert-heavy and delete-heavy phases, with a flood of one value
    // every fifth phase so counts climb to the capacity.
    for (i = 0; i < RANDOM_OPS; i++) begin
      phase = (i / 40) % 5;
      r     = $urandom_range(0, 99);
      r2    = $urandom_range(0, 9);
      if (r < 3) k = KIND_UNUSED;
      else if (phase == 4) k = (r < 65) ? slid_pkg::KIND_INSERT : slid_pkg::KIND_COUNT;
      else if ((phase % 2) == 0) begin
        k = (r < 60) ? slid_pkg::KIND_INSERT :
            (r < 80) ? slid_pkg::KIND_DELETE : slid_pkg::KIND_COUNT;
      end else begin
        k = (r < 25) ? slid_pkg::KIND_INSERT :
            (r < 75) ? slid_pkg::KIND_DELETE : slid_pkg::KIND_COUNT;
      end
      if (phase == 4 && r2 < 8) v = -32'sd1;
      else if (r2 == 0) v = slid_pkg::value_t'(32'h8000_0000);
      else if (r2 == 1) v = slid_pkg::value_t'(32'h7FFF_FFFF);
      else if (r2 < 8) v = slid_pkg::value_t'($urandom_range(0, 6)) - 32'sd3;
      else v = slid_pkg::value_t'($urandom);
      push_op(k, v);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (op_queue.size() != 0 || in_tvalid || pending_replies.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
